[hdl/ptcu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptcu_pkg
// Shared opcodes, result kinds and limits for the conversion unit.
// ----------------------------------------------------------------------------
package ptcu_pkg;

  typedef enum logic [3:0] {
    FN_I2L = 4'd0, FN_I2F = 4'd1, FN_I2D = 4'd2, FN_I2B = 4'd3,
    FN_I2C = 4'd4, FN_I2S = 4'd5, FN_L2I = 4'd6, FN_L2F = 4'd7,
    FN_L2D = 4'd8, FN_F2I = 4'd9, FN_F2L = 4'd10, FN_F2D = 4'd11,
    FN_D2I = 4'd12, FN_D2L = 4'd13, FN_D2F = 4'd14, FN_NONE = 4'd15
  } func_t;

  typedef enum logic [1:0] {
    KIND_INT = 2'd0, KIND_LONG = 2'd1, KIND_FLOAT = 2'd2, KIND_DOUBLE = 2'd3
  } kind_t;

  localparam logic [63:0] LIM_I32_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LIM_I32_MIN = 64'h0000_0000_8000_0000;
  localparam logic [63:0] LIM_I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_I64_MIN = 64'h8000_0000_0000_0000;

  // Position of the highest set bit (0 when zero).
  function automatic logic [5:0] top_bit(input logic [63:0] m);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

[hdl/ptcu_norm.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptcu_norm
// Registered leading-one search and left shift of a 64-bit magnitude.
// ----------------------------------------------------------------------------
module ptcu_norm (
  input  wire logic        clk,
  input  wire logic [63:0] mag,
  output logic      [63:0] norm,
  output logic       [5:0] msb
);
  logic [5:0] p_stage;
  logic [63:0] mag_stage;

  // search result registered in p_stage, then the shift registered in norm
  always_ff @(posedge clk) begin
    p_stage   <= ptcu_pkg::top_bit(mag);
    mag_stage <= mag;
    norm      <= mag_stage << (6'd63 - p_stage);
    msb       <= p_stage;
  end
endmodule
`default_nettype wire

[hdl/primitive_type_conversion_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// primitive_type_conversion_unit
// Numeric conversion bytecodes (i2l .. d2f) on raw IEEE / two's complement bits.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: func and operand_bits are taken at a rising edge with
//   start high and busy low. busy is tied low: one item may enter every
//   cycle. Opcode 15 is taken but gives no result.
//   Result channel: result_bits and result_kind are valid for exactly one
//   cycle with done high; the receiver cannot stall.
//   done rises with result_bits once the item has passed the stage registers
//   S1 through S5 in order; the result is registered out of S5.
//   Stages: S1 unpack to sign/magnitude/exponent, S2 leading-one search,
//   S3 normalizing shift, S4 round or integer shift, S5 pack and saturate.
//   Throughput: one item per cycle, set by the fully pipelined datapath.
//   Reset (rst, synchronous) clears the valid bits of all stages; payload
//   registers are not reset.
//   Float sources are widened to the double form in S1 (subnormals after S3), so all
//   float-to-int work shares the double path; integer-to-float shares one normalizer.
// ----------------------------------------------------------------------------
module primitive_type_conversion_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic  [3:0] func,
  input  wire logic [63:0] operand_bits,
  output logic             done,
  output logic      [63:0] result_bits,
  output logic       [1:0] result_kind
);
  typedef struct packed {
    logic       v;
    logic [3:0] fn;
    logic       neg;
    logic [63:0] raw;   // source bits (double form for float sources, signed zero for float subnormals)
    logic [63:0] mag;   // integer magnitude, or float subnormal fraction
    logic       fsub;   // float subnormal source
  } s1_t;

  s1_t s1, s2, s3;
  logic [63:0] norm;
  logic [5:0]  msb;

  assign busy = 1'b0;

  // ---------------- S1: unpack
  always_comb begin
    s1_t n;
    logic [31:0] lo;
    logic [7:0]  fe;
    logic [22:0] ff;
    n = '0;
    lo = operand_bits[31:0];
    fe = lo[30:23];
    ff = lo[22:0];
    n.v  = start;
    n.fn = func;
    n.raw = operand_bits;
    unique case (ptcu_pkg::func_t'(func))
      ptcu_pkg::FN_I2F, ptcu_pkg::FN_I2D: begin
        n.neg = lo[31];
        n.mag = lo[31] ? {32'd0, 32'(-lo)} : {32'd0, lo};
      end
      ptcu_pkg::FN_L2F, ptcu_pkg::FN_L2D: begin
        n.neg = operand_bits[63];
        n.mag = operand_bits[63] ? -operand_bits : operand_bits;
      end
      ptcu_pkg::FN_F2I, ptcu_pkg::FN_F2L, ptcu_pkg::FN_F2D: begin
        n.neg = lo[31];
        if (fe == 8'hFF)
          n.raw = {lo[31], 11'h7FF, (ff == 23'd0) ? 52'd0 : {1'b1, ff[21:0], 29'd0}};
        else if (fe == 8'd0) begin
          n.raw  = {lo[31], 63'd0};
          n.fsub = (ff != 23'd0);
          n.mag  = {41'd0, ff};
        end else
          n.raw = {lo[31], (fe[7] ? 4'b1000 : 4'b0111), fe[6:0], ff, 29'd0};
      end
      default: n.neg = operand_bits[63];
    endcase
    // rebuilt exponent for normal floats: e - 127 + 1023
    if ((func == ptcu_pkg::FN_F2I || func == ptcu_pkg::FN_F2L ||
         func == ptcu_pkg::FN_F2D) && fe != 8'hFF && fe != 8'd0)
      n.raw[62:52] = 11'({3'd0, fe} + 11'd896);
    s1 = n;
  end

  s1_t r1;
  always_ff @(posedge clk) begin
    if (rst) r1.v <= 1'b0;
    else     r1.v <= s1.v;
    {r1.fn, r1.neg, r1.raw, r1.mag, r1.fsub} <=
      {s1.fn, s1.neg, s1.raw, s1.mag, s1.fsub};
  end

  // ---------------- S2/S3: normalize (two register stages)
  ptcu_norm u_norm (.clk(clk), .mag(r1.mag), .norm(norm), .msb(msb));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.v <= 1'b0;
      s3.v <= 1'b0;
    end else begin
      s2.v <= r1.v;
      s3.v <= s2.v;
    end
    {s2.fn, s2.neg, s2.raw, s2.mag, s2.fsub} <=
      {r1.fn, r1.neg, r1.raw, r1.mag, r1.fsub};
    {s3.fn, s3.neg, s3.raw, s3.mag, s3.fsub} <=
      {s2.fn, s2.neg, s2.raw, s2.mag, s2.fsub};
  end

  // float subnormal widened to double: exponent p-149+1023
  logic [63:0] dsrc;
  always_comb begin
    dsrc = s3.raw;
    if (s3.fsub)
      dsrc = {s3.raw[63], 11'({5'd0, msb} + 11'd874), norm[62:11]};
  end

  // ---------------- S4: round / integer shift
  logic        v4, neg4;
  logic [3:0]  fn4;
  logic [63:0] dsrc4, pass4;
  logic [53:0] k4;       // rounded mantissa (int->fp, d2f)
  logic [11:0] e4;       // exponent before packing
  logic        sat4, zero4;
  logic [63:0] mag4;

  logic [53:0] k4_n;
  logic [11:0] e4_n;
  logic        sat4_n, zero4_n;
  logic [63:0] mag4_n;
  logic [63:0] pass4_n;

  always_comb begin
    logic [10:0] de;
    logic [52:0] m;
    logic [63:0] sh;
    logic [63:0] keep, rem, half;
    logic        isfl, tofl;
    logic [6:0]  s;
    logic [53:0] k;
    logic [11:0] e;
    logic        sat, zr;
    logic [63:0] mg;
    logic [10:0] w;
    de = dsrc[62:52];
    m  = {1'b1, dsrc[51:0]};
    k = '0; e = '0; sat = 1'b0; zr = 1'b0; mg = '0;
    keep = '0; rem = '0; half = '0; sh = '0;
    isfl = (s3.fn == ptcu_pkg::FN_I2F || s3.fn == ptcu_pkg::FN_L2F);
    tofl = isfl || s3.fn == ptcu_pkg::FN_I2D || s3.fn == ptcu_pkg::FN_L2D;
    s = '0;
    w = (s3.fn == ptcu_pkg::FN_F2L || s3.fn == ptcu_pkg::FN_D2L) ? 11'd63 : 11'd31;
    if (tofl) begin
      // norm holds the leading one at bit 63
      s = isfl ? 7'd40 : 7'd11;
      keep = norm >> s;
      rem  = norm & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 7'd1);
      k = 54'(keep) + 54'((rem > half || (rem == half && keep[0])) ? 1 : 0);
      e = {6'd0, msb};
      zr = (s3.mag == 64'd0);
    end else if (s3.fn == ptcu_pkg::FN_D2F) begin
      e = 12'({1'b0, de}) - 12'd1023;
      if (de == 11'd0 || de == 11'h7FF) begin
        zr = (de == 11'd0);
      end else if ($signed(e) > 12'sd127) begin
        sat = 1'b1;
      end else if ($signed(e) >= -12'sd126) begin
        s = 7'd29;
      end else begin
        // subnormal: shift = -ue - 97
        sh = {52'd0, 12'(12'd0 - e - 12'd97)};
        if (sh >= 64'd54) zr = 1'b1;
        else s = 7'(sh);
      end
      if (s != 7'd0) begin
        keep = {11'd0, m} >> s;
        rem  = {11'd0, m} & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 7'd1);
        k = 54'(keep) + 54'((rem > half || (rem == half && keep[0])) ? 1 : 0);
      end
    end else begin
      // double -> integer, truncation toward zero
      e = 12'({1'b0, de}) - 12'd1023;
      if (de == 11'h7FF && dsrc[51:0] != 52'd0) zr = 1'b1;
      else if (de == 11'd0 || de < 11'd1023) zr = 1'b1;
      else if (de == 11'h7FF || e >= {1'b0, w}) sat = 1'b1;
      else if (e >= 12'd52) mg = {11'd0, m} << (e - 12'd52);
      else mg = {11'd0, m} >> (12'd52 - e);
    end
    k4_n = k; e4_n = e; sat4_n = sat; zero4_n = zr; mag4_n = mg;
  end

  always_comb begin
    pass4_n = s3.raw;
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= s3.v;
    fn4 <= s3.fn; neg4 <= s3.neg; dsrc4 <= dsrc; pass4 <= pass4_n;
    k4 <= k4_n; e4 <= e4_n; sat4 <= sat4_n; zero4 <= zero4_n; mag4 <= mag4_n;
  end

  // ---------------- S5: pack
  logic [63:0] r_n;
  ptcu_pkg::kind_t kd_n;
  always_comb begin
    logic [31:0] lo;
    logic [53:0] k;
    logic [11:0] e;
    logic [63:0] sg;
    lo = pass4[31:0];
    k = k4; e = e4;
    r_n = '0;
    sg = '0;
    kd_n = ptcu_pkg::KIND_INT;
    unique case (ptcu_pkg::func_t'(fn4))
      ptcu_pkg::FN_I2L: begin
        r_n = {{32{lo[31]}}, lo}; kd_n = ptcu_pkg::KIND_LONG;
      end
      ptcu_pkg::FN_I2B: r_n = {32'd0, {24{lo[7]}}, lo[7:0]};
      ptcu_pkg::FN_I2C: r_n = {48'd0, lo[15:0]};
      ptcu_pkg::FN_I2S: r_n = {32'd0, {16{lo[15]}}, lo[15:0]};
      ptcu_pkg::FN_L2I: r_n = {32'd0, lo};
      ptcu_pkg::FN_I2F, ptcu_pkg::FN_L2F: begin
        kd_n = ptcu_pkg::KIND_FLOAT;
        if (k[24]) begin k = k >> 1; e = e + 12'd1; end
        if (!zero4)
          r_n = {32'd0, neg4, 8'(e + 12'd127), k[22:0]};
      end
      ptcu_pkg::FN_I2D, ptcu_pkg::FN_L2D: begin
        kd_n = ptcu_pkg::KIND_DOUBLE;
        if (k[53]) begin k = k >> 1; e = e + 12'd1; end
        if (!zero4)
          r_n = {neg4, 11'(e + 12'd1023), k[51:0]};
      end
      ptcu_pkg::FN_F2D: begin
        kd_n = ptcu_pkg::KIND_DOUBLE; r_n = dsrc4;
      end
      ptcu_pkg::FN_D2F: begin
        kd_n = ptcu_pkg::KIND_FLOAT;
        if (dsrc4[62:52] == 11'h7FF)
          r_n = {32'd0, neg4, 8'hFF,
                 (dsrc4[51:0] == 52'd0) ? 23'd0 : {1'b1, dsrc4[50:29]}};
        else if (zero4) r_n = {32'd0, neg4, 31'd0};
        else if (sat4) r_n = {32'd0, neg4, 8'hFF, 23'd0};
        else if ($signed(e) >= -12'sd126) begin
          if (k[24]) begin k = k >> 1; e = e + 12'd1; end
          if ($signed(e) > 12'sd127) r_n = {32'd0, neg4, 8'hFF, 23'd0};
          else r_n = {32'd0, neg4, 8'(e + 12'd127), k[22:0]};
        end else
          r_n = {32'd0, neg4, 31'(k)};
      end
      ptcu_pkg::FN_F2I, ptcu_pkg::FN_D2I, ptcu_pkg::FN_F2L, ptcu_pkg::FN_D2L: begin
        if (fn4 == ptcu_pkg::FN_F2L || fn4 == ptcu_pkg::FN_D2L) begin
          kd_n = ptcu_pkg::KIND_LONG;
          if (zero4) r_n = '0;
          else if (sat4) r_n = neg4 ? ptcu_pkg::LIM_I64_MIN : ptcu_pkg::LIM_I64_MAX;
          else r_n = neg4 ? -mag4 : mag4;
        end else begin
          if (zero4) r_n = '0;
          else if (sat4) r_n = neg4 ? ptcu_pkg::LIM_I32_MIN : ptcu_pkg::LIM_I32_MAX;
          else begin
            sg = neg4 ? -mag4 : mag4;
            r_n = {32'd0, sg[31:0]};
          end
        end
      end
      default: r_n = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v4 && (fn4 != ptcu_pkg::FN_NONE);
    result_bits <= r_n;
    result_kind <= kd_n;
  end

endmodule
`default_nettype wire

[hdl/ptcu_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptcu_checker
// Port-level checks of the conversion unit, bound to the top level.
// ----------------------------------------------------------------------------
module ptcu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic  [3:0] func,
  input wire logic        done,
  input wire logic [63:0] result_bits,
  input wire logic  [1:0] result_kind
);
  // every accepted item gives a result, opcode 15 gives nothing
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func != ptcu_pkg::FN_NONE) |-> ##5 done)
    else $error("missing result");
  a_none: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && func != ptcu_pkg::FN_NONE, 5))
    else $error("spurious result");
  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_upper: assert property (@(posedge clk) disable iff (rst)
    (done && (result_kind == ptcu_pkg::KIND_INT || result_kind == ptcu_pkg::KIND_FLOAT))
      |-> result_bits[63:32] == 32'd0)
    else $error("upper half not zero");
endmodule

bind primitive_type_conversion_unit ptcu_checker u_ptcu_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
  .done(done), .result_bits(result_bits), .result_kind(result_kind)
);
`default_nettype wire
